// ===== design/hmbd_pkg.sv =====
`timescale 1ns / 1ps
package hmbd_pkg;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] bus_address;
    logic [7:0]  write_byte;
    logic [2:0]  button_index;
    logic        button_down_now;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic [1:0] route;
    logic [1:0] dma_kind;
    logic [7:0] dma_arg;
    logic [4:0] irq_flags;
  } out_beat_t;

  localparam logic [1:0] FUNC_READ   = 2'd0;
  localparam logic [1:0] FUNC_WRITE  = 2'd1;
  localparam logic [1:0] FUNC_BUTTON = 2'd2;

  localparam logic [1:0] ROUTE_INSIDE = 2'd0;
  localparam logic [1:0] ROUTE_CART   = 2'd1;
  localparam logic [1:0] ROUTE_AUDIO  = 2'd2;

  localparam logic [1:0] DMA_NONE = 2'd0;
  localparam logic [1:0] DMA_OBJ  = 2'd1;
  localparam logic [1:0] DMA_HDMA = 2'd2;

  localparam logic CFG_COLOR_MODE = 1'b0;
  localparam logic CFG_DOUBLE_SPEED = 1'b1;

  typedef enum logic [2:0] {
    MEM_NONE, MEM_VRAM, MEM_WRAM, MEM_OAM, MEM_HRAM, MEM_IO, MEM_BGP, MEM_OBP
  } mem_sel_t;

  typedef enum logic [1:0] {ST_IDLE, ST_WAIT, ST_OUT} state_t;

  function automatic logic [7:0] io_boot(input logic [6:0] a);
    logic [7:0] v;
    unique case (a)
      7'h00: v = 8'hCF; 7'h02: v = 8'h7E; 7'h04: v = 8'hAB; 7'h07: v = 8'hF8;
      7'h0F: v = 8'hE1; 7'h10: v = 8'h80; 7'h11: v = 8'hBF; 7'h12: v = 8'hF3;
      7'h13: v = 8'hFF; 7'h14: v = 8'hBF; 7'h16: v = 8'h3F; 7'h18: v = 8'hFF;
      7'h19: v = 8'hBF; 7'h1A: v = 8'h7F; 7'h1B: v = 8'hFF; 7'h1C: v = 8'h9F;
      7'h1D: v = 8'hFF; 7'h1E: v = 8'hBF; 7'h20: v = 8'hFF; 7'h23: v = 8'hBF;
      7'h24: v = 8'h77; 7'h25: v = 8'hF3; 7'h26: v = 8'hF1; 7'h40: v = 8'h91;
      7'h41: v = 8'h85; 7'h46: v = 8'hFF; 7'h47: v = 8'hFC; 7'h48: v = 8'hFF;
      7'h49: v = 8'hFF;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

// ===== design/handheld_memory_bus_decoder_top.sv =====
`timescale 1ns / 1ps
// The result beat is offered once the input beat has passed the RAM read, then execute and
// write-back into the output register.
// A new input beat is taken only in the idle state, after the previous result was accepted;
// the input is held off while a result waits for out_ready.
// Reset: after rst a clearing pass over addresses 0 to 32767 loads the RAMs with their reset
// contents, during which no input beat is taken; configuration writes are taken at any time.
module handheld_memory_bus_decoder_top #(
  parameter int WRAM_BANKS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  hmbd_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output hmbd_pkg::out_beat_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic                cfg_data
);
  import hmbd_pkg::*;

  state_t state, state_next;
  logic [15:0] clr_cnt;
  logic clearing;
  logic color_mode, double_speed_now;
  in_beat_t cur;
  out_beat_t res;

  logic [4:0] irq_enable, irq_flag;
  logic [7:0] p1_reg, stat_reg, lcdc_reg;
  logic [7:0] bg_idx, obj_idx;
  logic vid_bank;
  logic [2:0] work_bank;
  logic spd_armed;
  logic [7:0] buttons;

  mem_sel_t msel;
  logic [14:0] maddr;
  logic [7:0] vram_q, wram_q, oam_q, hram_q, io_q, bgp_q, obp_q;
  logic mem_we;
  logic [14:0] waddr;
  logic [7:0] wdata;
  mem_sel_t wsel;

  assign cfg_ready = 1'b1;
  assign clearing = !clr_cnt[15];
  assign in_ready = (state == ST_IDLE) && !clearing;
  assign out_valid = (state == ST_OUT);
  assign out_data = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode <= 1'b0;
      double_speed_now <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_COLOR_MODE) color_mode <= cfg_data;
      else double_speed_now <= cfg_data;
    end
  end

  // Address decode for the RAM read.
  logic [15:0] a;
  logic [2:0] wb_used;
  logic [3:0] wb_mod;
  always_comb begin
    a = in_data.bus_address;
    wb_mod = {1'b0, work_bank};
    for (int i = 0; i < 3; i++) begin
      if (wb_mod >= 4'(WRAM_BANKS)) wb_mod = wb_mod - 4'(WRAM_BANKS);
    end
    wb_used = wb_mod[2:0];
    if (wb_used == 3'd0) wb_used = 3'd1;
    msel = MEM_NONE;
    maddr = '0;
    if (a == 16'hFF0F || a == 16'hFFFF) begin
      msel = MEM_NONE;
    end else if (a <= 16'h7FFF || (a >= 16'hA000 && a <= 16'hBFFF)) begin
      msel = MEM_NONE;
    end else if (a <= 16'h9FFF) begin
      msel = MEM_VRAM;
      maddr = {1'b0, vid_bank, a[12:0]};
    end else if (a <= 16'hFDFF) begin
      msel = MEM_WRAM;
      maddr = {(a[12] ? wb_used : 3'd0), a[11:0]};
    end else if (a <= 16'hFE9F) begin
      msel = MEM_OAM;
      maddr = 15'(a[7:0]);
    end else if (a <= 16'hFEFF) begin
      msel = MEM_NONE;
    end else if (a >= 16'hFF80) begin
      msel = MEM_HRAM;
      maddr = 15'(a[6:0]);
    end else if (color_mode && a == 16'hFF69) begin
      msel = MEM_BGP;
      maddr = 15'(bg_idx[5:0]);
    end else if (color_mode && a == 16'hFF6B) begin
      msel = MEM_OBP;
      maddr = 15'(obj_idx[5:0]);
    end else begin
      msel = MEM_IO;
      maddr = 15'(a[6:0]);
    end
  end

  mem_sel_t msel_q;
  logic [14:0] maddr_q;

  // Clearing pass writes reset contents; otherwise the item's write-back.
  logic we_v, we_w, we_o, we_h, we_i, we_b, we_p;
  logic [14:0] wa;
  logic [7:0] wd_zero_io, wd_pal;
  always_comb begin
    wa = clearing ? clr_cnt[14:0] : waddr;
    wd_zero_io = clearing ? io_boot(clr_cnt[6:0]) : wdata;
    wd_pal = clearing ? 8'hFF : wdata;
    we_v = clearing || (mem_we && wsel == MEM_VRAM);
    we_w = clearing || (mem_we && wsel == MEM_WRAM);
    we_o = clearing || (mem_we && wsel == MEM_OAM);
    we_h = clearing || (mem_we && wsel == MEM_HRAM);
    we_i = clearing || (mem_we && wsel == MEM_IO);
    we_b = clearing || (mem_we && wsel == MEM_BGP);
    we_p = clearing || (mem_we && wsel == MEM_OBP);
  end

  logic [7:0] wd_ram;
  assign wd_ram = clearing ? 8'h00 : wdata;

  hmbd_ram #(.AW(14)) u_vram (.clk, .we(we_v), .waddr(wa[13:0]), .wdata(wd_ram),
    .raddr(maddr[13:0]), .rdata(vram_q));
  hmbd_ram #(.AW(15)) u_wram (.clk, .we(we_w), .waddr(wa), .wdata(wd_ram),
    .raddr(maddr), .rdata(wram_q));
  hmbd_ram #(.AW(8)) u_oam (.clk, .we(we_o), .waddr(wa[7:0]), .wdata(wd_ram),
    .raddr(maddr[7:0]), .rdata(oam_q));
  hmbd_ram #(.AW(7)) u_hram (.clk, .we(we_h), .waddr(wa[6:0]), .wdata(wd_ram),
    .raddr(maddr[6:0]), .rdata(hram_q));
  hmbd_ram #(.AW(7)) u_io (.clk, .we(we_i), .waddr(wa[6:0]), .wdata(wd_zero_io),
    .raddr(maddr[6:0]), .rdata(io_q));
  hmbd_ram #(.AW(6)) u_bgp (.clk, .we(we_b), .waddr(wa[5:0]), .wdata(wd_pal),
    .raddr(maddr[5:0]), .rdata(bgp_q));
  hmbd_ram #(.AW(6)) u_obp (.clk, .we(we_p), .waddr(wa[5:0]), .wdata(wd_pal),
    .raddr(maddr[5:0]), .rdata(obp_q));

  always_comb begin
    unique case (state)
      ST_IDLE: state_next = (in_valid && in_ready) ? ST_WAIT : ST_IDLE;
      ST_WAIT: state_next = ST_OUT;
      ST_OUT: state_next = out_ready ? ST_IDLE : ST_OUT;
      default: state_next = ST_IDLE;
    endcase
  end

  // Execute step: data from RAM is valid in ST_WAIT.
  out_beat_t r;
  logic [7:0] mq, joy, lines, v;
  logic [15:0] ca;
  logic [7:0] bit_mask;
  logic [4:0] irq_next;
  always_comb begin
    ca = cur.bus_address;
    v = cur.write_byte;
    unique case (msel_q)
      MEM_VRAM: mq = vram_q;
      MEM_WRAM: mq = wram_q;
      MEM_OAM: mq = oam_q;
      MEM_HRAM: mq = hram_q;
      MEM_IO: mq = io_q;
      MEM_BGP: mq = bgp_q;
      MEM_OBP: mq = obp_q;
      default: mq = 8'hFF;
    endcase
    lines = 8'h0F;
    if (!p1_reg[4]) lines = lines & ~{4'h0, buttons[3:0]};
    if (!p1_reg[5]) lines = lines & ~{4'h0, buttons[7:4]};
    joy = 8'hC0 | (p1_reg & 8'h30) | lines;
    bit_mask = 8'd1 << cur.button_index;
    irq_next = irq_flag;
    if (cur.func == FUNC_BUTTON && cur.button_down_now) begin
      irq_next = irq_flag | 5'h10;
    end else if (cur.func == FUNC_WRITE && ca == 16'hFF0F) begin
      irq_next = v[4:0];
    end else if (cur.func == FUNC_WRITE && ca == 16'hFF41 && !color_mode && lcdc_reg[7] &&
                 (stat_reg[1:0] == 2'd0 || stat_reg[1:0] == 2'd1 || stat_reg[2])) begin
      irq_next = irq_flag | 5'h02;
    end
    r = '{read_byte: 8'hFF, route: ROUTE_INSIDE, dma_kind: DMA_NONE, dma_arg: 8'h00,
          irq_flags: irq_next};
    mem_we = 1'b0;
    waddr = maddr_q;
    wdata = v;
    wsel = msel_q;
    if (cur.func == FUNC_READ) begin
      priority if (ca == 16'hFF0F) r.read_byte = {3'b111, irq_flag};
      else if (ca == 16'hFFFF) r.read_byte = {3'b000, irq_enable};
      else if (ca <= 16'h7FFF || (ca >= 16'hA000 && ca <= 16'hBFFF)) r.route = ROUTE_CART;
      else if (ca <= 16'hFEFF) r.read_byte = mq;
      else if (ca >= 16'hFF80) r.read_byte = mq;
      else if (ca == 16'hFF00) r.read_byte = joy;
      else if (ca >= 16'hFF10 && ca <= 16'hFF3F) r.route = ROUTE_AUDIO;
      else if (color_mode && ca == 16'hFF4D)
        r.read_byte = {double_speed_now, 6'h3F, spd_armed};
      else if (color_mode && ca == 16'hFF4F) r.read_byte = {7'h7F, vid_bank};
      else if (color_mode && ca == 16'hFF70) r.read_byte = {5'h1F, work_bank};
      else if (color_mode && ca == 16'hFF68) r.read_byte = bg_idx | 8'h40;
      else if (color_mode && ca == 16'hFF6A) r.read_byte = obj_idx | 8'h40;
      else if (color_mode && (ca == 16'hFF69 || ca == 16'hFF6B)) r.read_byte = mq;
      else if (color_mode && ca == 16'hFF55) r.read_byte = 8'hFF;
      else if (ca == 16'hFF03 || (ca >= 16'hFF08 && ca <= 16'hFF0E) || ca >= 16'hFF4C)
        r.read_byte = 8'hFF;
      else if (ca == 16'hFF41) r.read_byte = stat_reg;
      else if (ca == 16'hFF40) r.read_byte = lcdc_reg;
      else r.read_byte = mq;
    end else if (cur.func == FUNC_WRITE) begin
      priority if (ca == 16'hFF46) begin
        r.dma_kind = DMA_OBJ;
        r.dma_arg = v;
      end else if (ca == 16'hFF0F || ca == 16'hFFFF) begin
      end else if (ca >= 16'hFEA0 && ca <= 16'hFEFF) begin
      end else if (ca <= 16'h7FFF || (ca >= 16'hA000 && ca <= 16'hBFFF)) begin
        r.route = ROUTE_CART;
      end else if (ca <= 16'hFE9F || ca >= 16'hFF80) begin
        mem_we = 1'b1;
      end else if (ca == 16'hFF00 || ca == 16'hFF04 || ca == 16'hFF41) begin
        mem_we = 1'b1;
        if (ca == 16'hFF04) wdata = 8'h00;
        if (ca == 16'hFF00) wdata = (v & 8'h30) | (p1_reg & 8'hCF);
        if (ca == 16'hFF41) wdata = (stat_reg & 8'h07) | (v & 8'h78) | 8'h80;
      end else if (color_mode && (ca == 16'hFF4D || ca == 16'hFF4F || ca == 16'hFF70 ||
                                  ca == 16'hFF68 || ca == 16'hFF6A)) begin
      end else if (color_mode && (ca == 16'hFF69 || ca == 16'hFF6B)) begin
        mem_we = 1'b1;
      end else if (color_mode && ca == 16'hFF55) begin
        r.dma_kind = DMA_HDMA;
        r.dma_arg = v;
      end else if (ca >= 16'hFF10 && ca <= 16'hFF3F) begin
        r.route = ROUTE_AUDIO;
      end else begin
        mem_we = 1'b1;
      end
    end
    if (state != ST_WAIT) mem_we = 1'b0;
  end

  logic [7:0] stat_w;
  always_comb begin
    stat_w = (stat_reg & 8'h07) | (cur.write_byte & 8'h78) | 8'h80;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      clr_cnt <= '0;
      irq_enable <= '0;
      irq_flag <= 5'h01;
      p1_reg <= 8'hCF;
      stat_reg <= 8'h85;
      lcdc_reg <= 8'h91;
      bg_idx <= '0;
      obj_idx <= '0;
      vid_bank <= 1'b0;
      work_bank <= 3'd1;
      spd_armed <= 1'b0;
      buttons <= '0;
    end else begin
      state <= state_next;
      if (clearing) clr_cnt <= clr_cnt + 16'd1;
      if (state == ST_WAIT) begin
        res <= r;
        irq_flag <= irq_next;
        if (cur.func == FUNC_BUTTON) begin
          if (cur.button_down_now) begin
            buttons <= buttons | bit_mask;
          end else begin
            buttons <= buttons & ~bit_mask;
          end
        end else if (cur.func == FUNC_WRITE) begin
          if (ca == 16'hFF0F) begin
          end else if (ca == 16'hFFFF) begin
            irq_enable <= v[4:0];
          end else if (ca == 16'hFF00) begin
            p1_reg <= (v & 8'h30) | (p1_reg & 8'hCF);
          end else if (ca == 16'hFF40) begin
            lcdc_reg <= v;
          end else if (ca == 16'hFF41) begin
            stat_reg <= stat_w;
          end else if (color_mode) begin
            if (ca == 16'hFF4D) spd_armed <= v[0];
            if (ca == 16'hFF4F) vid_bank <= v[0];
            if (ca == 16'hFF70) work_bank <= (v[2:0] == 3'd0) ? 3'd1 : v[2:0];
            if (ca == 16'hFF68) bg_idx <= v & 8'hBF;
            if (ca == 16'hFF6A) obj_idx <= v & 8'hBF;
            if (ca == 16'hFF69 && bg_idx[7]) bg_idx <= {2'b10, bg_idx[5:0] + 6'd1};
            if (ca == 16'hFF6B && obj_idx[7]) obj_idx <= {2'b10, obj_idx[5:0] + 6'd1};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cur <= in_data;
      msel_q <= msel;
      maddr_q <= maddr;
    end
  end

endmodule

// ===== design/hmbd_ram.sv =====
`timescale 1ns / 1ps
module hmbd_ram #(
  parameter int AW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);
  logic [7:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== test/handheld_memory_bus_decoder_top_tb.sv =====
`timescale 1ns / 1ps
module handheld_memory_bus_decoder_top_tb;
  import hmbd_pkg::*;

  localparam int NUM_BANKS = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_beat_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic cfg_data = 1'b0;

  handheld_memory_bus_decoder_top #(.WRAM_BANKS(NUM_BANKS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic [7:0] vram_m [0:16383];
  logic [7:0] wram_m [0:32767];
  logic [7:0] oam_m [0:159];
  logic [7:0] hram_m [0:126];
  logic [7:0] io_m [0:127];
  logic [7:0] bgpal_m [0:63];
  logic [7:0] obpal_m [0:63];
  logic [4:0] ie_m;
  logic [7:0] bg_idx_m, ob_idx_m;
  logic vbank_m;
  logic [2:0] wbank_m;
  logic armed_m;
  logic [7:0] held_m;
  logic color_m, dspeed_m;

  in_beat_t pending_beats [$];
  out_beat_t expected_beats [$];
  int errors = 0;
  int cycles = 0;
  int reads_seen = 0, writes_seen = 0, buttons_seen = 0, dma_seen = 0, routed_seen = 0;
  bit hold_off = 0;
  bit quiet_in = 0, quiet_out = 0;

  task automatic model_reset();
    for (int i = 0; i < 16384; i++) vram_m[i] = 8'h00;
    for (int i = 0; i < 32768; i++) wram_m[i] = 8'h00;
    for (int i = 0; i < 160; i++) oam_m[i] = 8'h00;
    for (int i = 0; i < 127; i++) hram_m[i] = 8'h00;
    for (int i = 0; i < 128; i++) io_m[i] = 8'h00;
    for (int i = 0; i < 64; i++) begin
      bgpal_m[i] = 8'hFF;
      obpal_m[i] = 8'hFF;
    end
    io_m['h00] = 8'hCF; io_m['h02] = 8'h7E; io_m['h04] = 8'hAB; io_m['h07] = 8'hF8;
    io_m['h0F] = 8'hE1; io_m['h10] = 8'h80; io_m['h11] = 8'hBF; io_m['h12] = 8'hF3;
    io_m['h13] = 8'hFF; io_m['h14] = 8'hBF; io_m['h16] = 8'h3F; io_m['h18] = 8'hFF;
    io_m['h19] = 8'hBF; io_m['h1A] = 8'h7F; io_m['h1B] = 8'hFF; io_m['h1C] = 8'h9F;
    io_m['h1D] = 8'hFF; io_m['h1E] = 8'hBF; io_m['h20] = 8'hFF; io_m['h23] = 8'hBF;
    io_m['h24] = 8'h77; io_m['h25] = 8'hF3; io_m['h26] = 8'hF1; io_m['h40] = 8'h91;
    io_m['h41] = 8'h85; io_m['h46] = 8'hFF; io_m['h47] = 8'hFC; io_m['h48] = 8'hFF;
    io_m['h49] = 8'hFF;
    ie_m = '0; bg_idx_m = '0; ob_idx_m = '0; vbank_m = 0; wbank_m = 3'd1;
    armed_m = 0; held_m = '0; color_m = 0; dspeed_m = 0;
  endtask

  function automatic int vram_slot(logic [15:0] a);
    return int'(vbank_m) * 8192 + int'(a[12:0]);
  endfunction

  function automatic int wram_slot(logic [15:0] a);
    int bank;
    bank = 0;
    if (a[12]) begin
      bank = int'(wbank_m) % NUM_BANKS;
      if (bank == 0) bank = 1;
    end
    return (bank * 4096 + int'(a[11:0])) & 32'h7FFF;
  endfunction

  function automatic logic [7:0] next_pal_index(logic [7:0] idx);
    if (idx[7]) return {2'b10, 6'(idx[5:0] + 6'd1)};
    return idx;
  endfunction

  function automatic logic [7:0] bus_read_model(logic [15:0] a, inout logic [1:0] route);
    logic [7:0] lines, p1;
    if (a == 16'hFF0F) return io_m['h0F] | 8'hE0;
    if (a == 16'hFFFF) return {3'b000, ie_m};
    if (a <= 16'h7FFF || (a >= 16'hA000 && a <= 16'hBFFF)) begin
      route = ROUTE_CART;
      return 8'hFF;
    end
    if (a <= 16'h9FFF) return vram_m[vram_slot(a)];
    if (a <= 16'hFDFF) return wram_m[wram_slot(a)];
    if (a <= 16'hFE9F) return oam_m[a - 16'hFE00];
    if (a <= 16'hFEFF) return 8'hFF;
    if (a >= 16'hFF80) return hram_m[a - 16'hFF80];
    if (a == 16'hFF00) begin
      p1 = io_m[0];
      lines = 8'h0F;
      if (!p1[4]) lines &= ~{4'h0, held_m[3:0]};
      if (!p1[5]) lines &= ~{4'h0, held_m[7:4]};
      return 8'hC0 | (p1 & 8'h30) | lines;
    end
    if (a >= 16'hFF10 && a <= 16'hFF3F) begin
      route = ROUTE_AUDIO;
      return 8'hFF;
    end
    if (color_m) begin
      case (a)
        16'hFF4D: return {dspeed_m, 6'h3F, armed_m};
        16'hFF4F: return {7'h7F, vbank_m};
        16'hFF70: return {5'h1F, wbank_m};
        16'hFF68: return bg_idx_m | 8'h40;
        16'hFF69: return bgpal_m[bg_idx_m[5:0]];
        16'hFF6A: return ob_idx_m | 8'h40;
        16'hFF6B: return obpal_m[ob_idx_m[5:0]];
        16'hFF55: return 8'hFF;
        default: ;
      endcase
    end
    if (a == 16'hFF03 || (a >= 16'hFF08 && a <= 16'hFF0E) || a >= 16'hFF4C) return 8'hFF;
    return io_m[a[6:0]];
  endfunction

  function automatic void bus_write_model(logic [15:0] a, logic [7:0] v,
                                          inout out_beat_t r);
    if (a == 16'hFF46) begin
      r.dma_kind = DMA_OBJ; r.dma_arg = v;
      return;
    end
    if (a == 16'hFF0F) begin
      io_m['h0F] = v & 8'h1F;
      return;
    end
    if (a == 16'hFFFF) begin
      ie_m = v[4:0];
      return;
    end
    if (a >= 16'hFEA0 && a <= 16'hFEFF) return;
    if (a <= 16'h7FFF || (a >= 16'hA000 && a <= 16'hBFFF)) begin
      r.route = ROUTE_CART;
      return;
    end
    if (a <= 16'h9FFF) begin
      vram_m[vram_slot(a)] = v;
      return;
    end
    if (a <= 16'hFDFF) begin
      wram_m[wram_slot(a)] = v;
      return;
    end
    if (a <= 16'hFE9F) begin
      oam_m[a - 16'hFE00] = v;
      return;
    end
    if (a >= 16'hFF80) begin
      hram_m[a - 16'hFF80] = v;
      return;
    end
    if (a == 16'hFF00) begin
      io_m[0] = (v & 8'h30) | (io_m[0] & 8'hCF);
      return;
    end
    if (a == 16'hFF04) begin
      io_m[4] = 8'h00;
      return;
    end
    if (a == 16'hFF41) begin
      if (!color_m && io_m['h40][7] &&
          (io_m['h41][1:0] == 2'd0 || io_m['h41][1:0] == 2'd1 || io_m['h41][2]))
        io_m['h0F] |= 8'h02;
      io_m['h41] = (io_m['h41] & 8'h07) | (v & 8'h78) | 8'h80;
      return;
    end
    if (color_m) begin
      case (a)
        16'hFF4D: begin armed_m = v[0]; return; end
        16'hFF4F: begin vbank_m = v[0]; return; end
        16'hFF70: begin
          wbank_m = (v[2:0] == 3'd0) ? 3'd1 : v[2:0];
          return;
        end
        16'hFF68: begin bg_idx_m = v & 8'hBF; return; end
        16'hFF69: begin
          bgpal_m[bg_idx_m[5:0]] = v;
          bg_idx_m = next_pal_index(bg_idx_m);
          return;
        end
        16'hFF6A: begin ob_idx_m = v & 8'hBF; return; end
        16'hFF6B: begin
          obpal_m[ob_idx_m[5:0]] = v;
          ob_idx_m = next_pal_index(ob_idx_m);
          return;
        end
        16'hFF55: begin
          r.dma_kind = DMA_HDMA; r.dma_arg = v;
          return;
        end
        default: ;
      endcase
    end
    if (a >= 16'hFF10 && a <= 16'hFF3F) begin
      r.route = ROUTE_AUDIO;
      return;
    end
    io_m[a[6:0]] = v;
  endfunction

  function automatic out_beat_t decode_beat(in_beat_t b);
    out_beat_t r;
    logic [1:0] route;
    r = '0;
    r.read_byte = 8'hFF;
    route = ROUTE_INSIDE;
    if (b.func == FUNC_READ) begin
      r.read_byte = bus_read_model(b.bus_address, route);
      r.route = route;
    end else if (b.func == FUNC_WRITE) begin
      bus_write_model(b.bus_address, b.write_byte, r);
    end else if (b.func == FUNC_BUTTON) begin
      if (b.button_down_now) begin
        held_m[b.button_index] = 1'b1;
        io_m['h0F] |= 8'h10;
      end else begin
        held_m[b.button_index] = 1'b0;
      end
    end
    r.irq_flags = io_m['h0F][4:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_beats.size() > 0 && (quiet_in || $urandom_range(99) >= 12)) begin
        in_data <= pending_beats.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (in_valid && in_ready && !rst) begin
      expected_beats.push_back(decode_beat(in_data));
      case (in_data.func)
        FUNC_READ: reads_seen++;
        FUNC_WRITE: writes_seen++;
        default: buttons_seen++;
      endcase
    end
    if (out_valid && out_ready && !rst) begin
      if (expected_beats.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat %h", $time, out_data);
      end else begin
        out_beat_t e;
        e = expected_beats.pop_front();
        if (e.dma_kind != DMA_NONE) dma_seen++;
        if (e.route != ROUTE_INSIDE) routed_seen++;
        if (e.read_byte !== out_data.read_byte)
          $display("%0t: read_byte expected %h actual %h", $time, e.read_byte,
                   out_data.read_byte);
        if (e.route !== out_data.route)
          $display("%0t: route expected %h actual %h", $time, e.route, out_data.route);
        if (e.dma_kind !== out_data.dma_kind)
          $display("%0t: dma_kind expected %h actual %h", $time, e.dma_kind,
                   out_data.dma_kind);
        if (e.dma_arg !== out_data.dma_arg)
          $display("%0t: dma_arg expected %h actual %h", $time, e.dma_arg,
                   out_data.dma_arg);
        if (e.irq_flags !== out_data.irq_flags)
          $display("%0t: irq_flags expected %h actual %h", $time, e.irq_flags,
                   out_data.irq_flags);
        if (e !== out_data) errors++;
      end
    end
    out_ready <= !rst && !hold_off && (quiet_out || $urandom_range(99) >= 12);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_COLOR_MODE) color_m = val;
    else dspeed_m = val;
  endtask

  task automatic drain();
    while (pending_beats.size() > 0 || in_valid || expected_beats.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic in_beat_t make_beat(logic [1:0] f, logic [15:0] a, logic [7:0] d,
                                         logic [2:0] bi = 3'd0, logic dn = 1'b0);
    in_beat_t b;
    b.func = f; b.bus_address = a; b.write_byte = d;
    b.button_index = bi; b.button_down_now = dn;
    return b;
  endfunction

  function automatic logic [15:0] pick_address();
    case ($urandom_range(9))
      0: return 16'($urandom_range(16'h8000, 16'h9FFF));
      1, 2: return 16'($urandom_range(16'hC000, 16'hFDFF));
      3: return 16'($urandom_range(16'hFE00, 16'hFEFF));
      4: return 16'($urandom_range(16'hFF80, 16'hFFFF));
      5, 6: return 16'($urandom_range(16'hFF00, 16'hFF7F));
      7: begin
        case ($urandom_range(7))
          0: return 16'hFF4D; 1: return 16'hFF4F; 2: return 16'hFF70;
          3: return 16'hFF68; 4: return 16'hFF69; 5: return 16'hFF6A;
          6: return 16'hFF6B; default: return 16'hFF55;
        endcase
      end
      8: return 16'($urandom_range(16'hFF40, 16'hFF46));
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(19))
        0: pending_beats.push_back(make_beat(FUNC_BUTTON, 16'($urandom()), 8'($urandom()),
                                             3'($urandom()), 1'($urandom())));
        1: pending_beats.push_back(make_beat(FUNC_UNUSED, 16'($urandom()), 8'($urandom()),
                                             3'($urandom()), 1'($urandom())));
        2, 3, 4, 5, 6, 7, 8, 9:
          pending_beats.push_back(make_beat(FUNC_READ, pick_address(), 8'($urandom())));
        default:
          pending_beats.push_back(make_beat(FUNC_WRITE, pick_address(), 8'($urandom())));
      endcase
    end
    drain();
  endtask

  initial begin
    model_reset();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    pending_beats.push_back(make_beat(FUNC_READ, 16'hFF00, 8'h00));
    pending_beats.push_back(make_beat(FUNC_BUTTON, 16'h0000, 8'h00, 3'd7, 1'b1));
    pending_beats.push_back(make_beat(FUNC_BUTTON, 16'h0000, 8'h00, 3'd0, 1'b1));
    pending_beats.push_back(make_beat(FUNC_WRITE, 16'hFF00, 8'hEF));
    pending_beats.push_back(make_beat(FUNC_READ, 16'hFF00, 8'h00));
    pending_beats.push_back(make_beat(FUNC_WRITE, 16'hFF00, 8'hDF));
    pending_beats.push_back(make_beat(FUNC_READ, 16'hFF00, 8'h00));
    pending_beats.push_back(make_beat(FUNC_BUTTON, 16'hFFFF, 8'hFF, 3'd7, 1'b0));
    pending_beats.push_back(make_beat(FUNC_WRITE, 16'hFF04, 8'hFF));
    pending_beats.push_back(make_beat(FUNC_READ, 16'hFF04, 8'h00));
    pending_beats.push_back(make_beat(FUNC_WRITE, 16'hFF41, 8'hFF));
    pending_beats.push_back(make_beat(FUNC_READ, 16'hFF41, 8'h00));
    pending_beats.push_back(make_beat(FUNC_WRITE, 16'hFF46, 8'hC1));
    pending_beats.push_back(make_beat(FUNC_WRITE, 16'hFEA0, 8'h55));
    pending_beats.push_back(make_beat(FUNC_READ, 16'hFEFF, 8'h00));
    pending_beats.push_back(make_beat(FUNC_WRITE, 16'hFF03, 8'h12));
    pending_beats.push_back(make_beat(FUNC_READ, 16'hFF03, 8'h00));
    pending_beats.push_back(make_beat(FUNC_WRITE, 16'h0000, 8'h00));
    pending_beats.push_back(make_beat(FUNC_READ, 16'hBFFF, 8'h00));
    pending_beats.push_back(make_beat(FUNC_WRITE, 16'hFF26, 8'h80));
    pending_beats.push_back(make_beat(FUNC_WRITE, 16'hFFFF, 8'hFF));
    pending_beats.push_back(make_beat(FUNC_READ, 16'hFFFF, 8'h00));
    pending_beats.push_back(make_beat(FUNC_READ, 16'hFF0F, 8'h00));
    pending_beats.push_back(make_beat(FUNC_UNUSED, 16'hFFFF, 8'hFF, 3'd7, 1'b1));
    drain();

    write_reg(CFG_COLOR_MODE, 1'b1);
    write_reg(CFG_DOUBLE_SPEED, 1'b1);
    pending_beats.push_back(make_beat(FUNC_WRITE, 16'hFF70, 8'h00));
    pending_beats.push_back(make_beat(FUNC_WRITE, 16'hD000, 8'hA5));
    pending_beats.push_back(make_beat(FUNC_WRITE, 16'hFF4F, 8'hFF));
    pending_beats.push_back(make_beat(FUNC_WRITE, 16'h9FFF, 8'h5A));
    pending_beats.push_back(make_beat(FUNC_WRITE, 16'hFF68, 8'hBF));
    pending_beats.push_back(make_beat(FUNC_WRITE, 16'hFF69, 8'h11));
    pending_beats.push_back(make_beat(FUNC_READ, 16'hFF68, 8'h00));
    pending_beats.push_back(make_beat(FUNC_WRITE, 16'hFF55, 8'h83));
    pending_beats.push_back(make_beat(FUNC_READ, 16'hFF4D, 8'h00));
    drain();

    quiet_in = 1;
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      random_phase(320);
    join
    quiet_in = 0;

    write_reg(CFG_DOUBLE_SPEED, 1'b0);
    quiet_out = 1;
    random_phase(300);
    quiet_out = 0;

    write_reg(CFG_COLOR_MODE, 1'b0);
    random_phase(350);
    write_reg(CFG_COLOR_MODE, 1'b1);
    write_reg(CFG_DOUBLE_SPEED, 1'b1);
    random_phase(300);

    $display("Covered %0d reads, %0d writes, %0d button or unused beats;", reads_seen,
             writes_seen, buttons_seen);
    $display("%0d DMA requests and %0d routed accesses seen.", dma_seen, routed_seen);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
